// ----- rtl/fbpa_pkg.sv -----
package fbpa_pkg;

    // Fixed geometry of one block and of the bus addresses.
    localparam int ADDR_W      = 32;
    localparam int BLOCK_BYTES = 32;
    localparam int BLK_SHIFT   = $clog2(BLOCK_BYTES);
    localparam int IXW         = ADDR_W - BLK_SHIFT;
    localparam int POOL_BLK_W  = 9;

    // Configuration register map.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BLOCKS = 1'b1;

    // Request kinds carried on the input tuser.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

// ----- rtl/fbpa_ram.sv -----
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; the data holds until the next enabled read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/fixed_block_pool_allocator.sv -----
// Fixed-size block pool allocator.
// Input stream: s_axis_tuser carries the request kind (0 allocate, 1 free) and
// s_axis_tdata the byte address of the block to free (ignored for allocate).
// Output stream: one word per request. m_axis_tuser is the ok flag and
// m_axis_tdata the granted block address, zero on failure and on every free.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 pool base address, 1 number of blocks in use); write only while idle.
// Each request is accepted in the idle state, which reads the link memory
// (for an allocate) or the allocated-mark memory (for a free); the execute
// state then uses the registered read data and writes the memories back.
// The free list state is updated only at that write-back, so one request is
// in flight, and no new request is taken until that write-back is done.
// A finished result sits in the output register; the next request is accepted
// while it waits, but its write-back stalls until the receiver takes the word.
// Reset empties the free list, restarts the fresh-block counter at block 0 and
// drops any pending output. No clearing pass is needed: marks of blocks at or
// above the fresh-block counter read as not allocated.
module fixed_block_pool_allocator #(
    parameter int NUM_BLOCKS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]       i_cfg_data,
    // Request stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [fbpa_pkg::ADDR_W-1:0]       s_axis_tdata,  // [31:0] address
    input  logic                              s_axis_tuser,  // [0] op
    // Result stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [fbpa_pkg::ADDR_W-1:0]       m_axis_tdata,  // [31:0] block_address
    output logic                              m_axis_tuser   // [0] ok
);

    import fbpa_pkg::*;

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam logic [IXW-1:0] NB_IX = IXW'(NUM_BLOCKS);

    // Configuration registers.
    logic [ADDR_W-1:0]     r_pool_base;
    logic [POOL_BLK_W-1:0] r_pool_blocks;

    // Free list and fresh-block state.
    logic [IDX_W-1:0] r_head, n_head;
    logic             r_nonempty, n_nonempty;
    logic [CNT_W-1:0] r_fresh, n_fresh;

    // Request held between accept and write-back.
    t_state           r_state, n_state;
    logic             r_op;
    logic [IDX_W-1:0] r_idx;
    logic             r_free_pre;

    // Output register.
    logic              r_out_valid, n_out_valid;
    logic              r_out_ok, n_out_ok;
    logic [ADDR_W-1:0] r_out_addr, n_out_addr;

    // Memory ports.
    logic [IDX_W-1:0] link_rdata, link_wdata, link_waddr;
    logic             link_we;
    logic [0:0]       mark_rdata, mark_wdata;
    logic [IDX_W-1:0] mark_waddr;
    logic             mark_we;

    logic              accept;
    logic              commit;
    logic [ADDR_W-1:0] offset;
    logic [IXW-1:0]    off_idx;
    logic [IXW-1:0]    limit;
    logic [IXW-1:0]    fresh_ix;
    logic [IXW-1:0]    pool_ix;
    logic [IDX_W-1:0]  grant_idx;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign commit = (r_state == ST_EXEC) && (!r_out_valid || m_axis_tready);

    // Number of blocks in use, capped at the built capacity.
    assign pool_ix  = {{(IXW-POOL_BLK_W){1'b0}}, r_pool_blocks};
    assign limit    = (pool_ix > NB_IX) ? NB_IX : pool_ix;
    assign fresh_ix = {{(IXW-CNT_W){1'b0}}, r_fresh};

    // Free address decode: offset from the base, block index and alignment.
    assign offset  = s_axis_tdata - r_pool_base;
    assign off_idx = offset[ADDR_W-1:BLK_SHIFT];

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base   <= '0;
            r_pool_blocks <= POOL_BLK_W'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_POOL_BASE:   r_pool_base   <= i_cfg_data;
                CFG_POOL_BLOCKS: r_pool_blocks <= i_cfg_data[POOL_BLK_W-1:0];
                default:         ;
            endcase
        end
    end

    // Capture the request; a free is pre-checked for alignment, range and
    // for having been handed out at all.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= s_axis_tuser;
            r_idx      <= off_idx[IDX_W-1:0];
            r_free_pre <= (offset[BLK_SHIFT-1:0] == '0) && (off_idx < limit)
                          && (off_idx < fresh_ix);
        end
    end

    // Link memory: next entry of the free list, read at the head.
    fbpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (accept && (s_axis_tuser == OP_ALLOC)),
        .i_raddr (r_head),
        .o_rdata (link_rdata)
    );

    // Allocated marks, read at the block named by a free.
    fbpa_ram #(
        .WIDTH (1),
        .DEPTH (NUM_BLOCKS)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_re    (accept && (s_axis_tuser == OP_FREE)),
        .i_raddr (off_idx[IDX_W-1:0]),
        .o_rdata (mark_rdata)
    );

    // Write-back: next state, memory writes and the result word.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_nonempty  = r_nonempty;
        n_fresh     = r_fresh;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_ok    = r_out_ok;
        n_out_addr  = r_out_addr;
        link_we     = 1'b0;
        link_waddr  = r_idx;
        link_wdata  = r_nonempty ? r_head : r_idx;
        mark_we     = 1'b0;
        mark_waddr  = r_idx;
        mark_wdata  = 1'b0;
        grant_idx   = r_fresh[IDX_W-1:0];

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out_ok    = 1'b0;
                    n_out_addr  = '0;
                    if (r_op == OP_ALLOC) begin
                        // Reuse freed blocks first, then fresh ones.
                        if (r_nonempty) begin
                            grant_idx = r_head;
                            if (link_rdata == r_head) begin
                                n_nonempty = 1'b0;
                            end else begin
                                n_head = link_rdata;
                            end
                        end else if (fresh_ix < limit) begin
                            n_fresh = CNT_W'(r_fresh + 1'b1);
                        end
                        if (r_nonempty || (fresh_ix < limit)) begin
                            mark_we    = 1'b1;
                            mark_waddr = grant_idx;
                            mark_wdata = 1'b1;
                            n_out_ok   = 1'b1;
                            n_out_addr = r_pool_base +
                                {{(ADDR_W-IDX_W-BLK_SHIFT){1'b0}}, grant_idx,
                                 {BLK_SHIFT{1'b0}}};
                        end
                    end else if (r_free_pre && mark_rdata[0]) begin
                        // Push the block; the last entry links to itself.
                        mark_we    = 1'b1;
                        link_we    = 1'b1;
                        n_head     = r_idx;
                        n_nonempty = 1'b1;
                        n_out_ok   = 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_nonempty  <= 1'b0;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_nonempty  <= n_nonempty;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_out_ok   <= n_out_ok;
        r_out_addr <= n_out_addr;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_addr;
    assign m_axis_tuser  = r_out_ok;

endmodule

// ----- rtl/fbpa_checker.sv -----
module fbpa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [fbpa_pkg::ADDR_W-1:0] m_axis_tdata,
    input logic                        m_axis_tuser
);

    // Reset drops any pending result word.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word pending after reset");

    // One request in flight: the cycle after an accept takes no new request.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while another is in flight");

    // A failed allocate or a rejected free never reports an address.
    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("address reported on a failed request");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result word changed");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
